/* sv/thx_pkg.sv */
// Shared constants and state codes of the time history extrapolator.
package thx_pkg;

    localparam int TableDepth  = 32;
    localparam int MaxVector   = 16;
    localparam int SlotW       = $clog2(TableDepth);
    localparam int CountW      = $clog2(TableDepth + 1);
    localparam int ElemW       = $clog2(MaxVector);
    localparam int TimeW       = 48;
    localparam int ValW        = 32;
    localparam int LenW        = 5;
    localparam int InDataW     = 88;
    localparam int OutDataW    = 40;
    localparam int ProdW       = 81;
    localparam int MagW        = 33;

    localparam logic [CountW-1:0] CleanThreshold   = CountW'(20);
    localparam logic [SlotW-1:0]  CleanPosLimit    = SlotW'(3);
    localparam logic [CountW-1:0] CleanKeepReplace = CountW'(5);
    localparam logic [CountW-1:0] CleanKeepInsert  = CountW'(6);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CRD   = 5'd1;
    localparam logic [4:0] S_CCMP  = 5'd2;
    localparam logic [4:0] S_CCP   = 5'd3;
    localparam logic [4:0] S_CVAL  = 5'd4;
    localparam logic [4:0] S_QRD   = 5'd5;
    localparam logic [4:0] S_QCMP  = 5'd6;
    localparam logic [4:0] S_QRD2  = 5'd7;
    localparam logic [4:0] S_QCMP2 = 5'd8;
    localparam logic [4:0] S_V1    = 5'd9;
    localparam logic [4:0] S_V2    = 5'd10;
    localparam logic [4:0] S_SET   = 5'd11;
    localparam logic [4:0] S_MUL   = 5'd12;
    localparam logic [4:0] S_DIV   = 5'd13;
    localparam logic [4:0] S_FIN   = 5'd14;
    localparam logic [4:0] S_OUT   = 5'd15;

    localparam logic [0:0] REG_VECTOR_LENGTH = 1'b0;

endpackage

/* sv/thx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module thx_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/time_history_extrapolator.sv */
// Top level of the time history extrapolator: sorted time table and query engine.
//
// Input stream (s_axis): tuser is the mode (0 insert element, 1 query), tlast
// commits the staged vector on an insert. Output stream (m_axis): one beat per
// vector element of a query, tlast on the final one, tuser set for an empty table.
// An insert beat without tlast only stages its element. A commit walks the table
// entry by entry while the entries are newer than the new time, then writes the
// vector, one element a cycle, through the single write port of the value memory.
// A query walks the table entry by entry, then per element: a stored value goes
// straight to the output register, while an extrapolated one passes through the shared
// shift-add multiplier (33 steps) and restoring divider (81 steps).
// Each result beat waits in the output register until taken; s_axis_tready is
// low for the whole of an item, so a stalled receiver stalls the block.
// Synchronous reset empties the table and sets vector_length to 1; the memories
// are not cleared. vector_length is written over APB at address 0.
module time_history_extrapolator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [thx_pkg::InDataW-1:0] s_axis_tdata,   // time_req, elem_index, value
    input  logic                        s_axis_tlast,
    input  logic                        s_axis_tuser,   // mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [thx_pkg::OutDataW-1:0] m_axis_tdata,  // result_value, result_index
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser,   // status
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int SlotW  = thx_pkg::SlotW;
    localparam int CountW = thx_pkg::CountW;
    localparam int ElemW  = thx_pkg::ElemW;
    localparam int TimeW  = thx_pkg::TimeW;
    localparam int ValW   = thx_pkg::ValW;
    localparam int ProdW  = thx_pkg::ProdW;
    localparam int MagW   = thx_pkg::MagW;

    logic [4:0]             r_state;
    logic [thx_pkg::LenW-1:0] r_len;
    logic [CountW-1:0]      r_count;
    logic [SlotW-1:0]       r_ord [thx_pkg::TableDepth];
    logic [ValW-1:0]        r_stage [thx_pkg::MaxVector];
    logic [TimeW-1:0]       r_t;
    logic [CountW-1:0]      r_k;
    logic [CountW-1:0]      r_pos;
    logic                   r_rep;
    logic [SlotW-1:0]       r_slot;
    logic [ElemW-1:0]       r_vi;
    logic                   r_hn;
    logic [TimeW-1:0]       r_t1;
    logic [TimeW-1:0]       r_t2;
    logic [ValW-1:0]        r_v1;
    logic [ValW-1:0]        r_v2;
    logic [TimeW-1:0]       r_a;
    logic [MagW-1:0]        r_m;
    logic [TimeW-1:0]       r_d;
    logic                   r_neg;
    logic [ProdW-1:0]       r_prod;
    logic [TimeW-1:0]       r_rem;
    logic [6:0]             r_cnt;
    logic                   r_ov;
    logic [ValW-1:0]        r_oval;
    logic [ElemW-1:0]       r_oidx;
    logic                   r_olast;
    logic                   r_ostat;

    logic                   in_acc;
    logic [TimeW-1:0]       in_time;
    logic [ElemW-1:0]       in_idx;
    logic [ValW-1:0]        in_val;
    logic                   cfg_wr;

    logic [SlotW-1:0]       k0;
    logic [SlotW-1:0]       k1;
    logic [TimeW-1:0]       t_rdata;
    logic [ValW-1:0]        v_rdata;
    logic [SlotW-1:0]       t_raddr;
    logic [SlotW+ElemW-1:0] v_raddr;
    logic                   t_we;
    logic                   v_we;

    logic [SlotW-1:0]       ce;
    logic [SlotW-1:0]       cp;
    logic [SlotW-1:0]       cslot;
    logic [CountW-1:0]      ccount;
    logic [CountW-1:0]      n_count;
    logic [CountW-1:0]      keep;

    logic [ElemW-1:0]       last_idx;

    logic [MagW-1:0]        dv;
    logic                   s_neg;
    logic [MagW-1:0]        s_m;
    logic [TimeW-1:0]       s_a;
    logic [TimeW-1:0]       s_d;
    logic                   a_sw;
    logic                   d_sw;

    logic [TimeW:0]         rem_sh;
    logic [TimeW:0]         rem_df;
    logic                   rem_ge;

    logic                   q_sat;
    logic [42:0]            q_ext;
    logic [42:0]            sum;
    logic [ValW-1:0]        fin_val;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_time = s_axis_tdata[47:0];
    assign in_idx  = s_axis_tdata[51:48];
    assign in_val  = s_axis_tdata[83:52];
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == thx_pkg::REG_VECTOR_LENGTH)
                  ? {27'b0, r_len} : 32'b0;

    assign s_axis_tready = (r_state == thx_pkg::S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'b0, r_oidx, r_oval};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ostat;

    assign k0 = r_k[SlotW-1:0];
    assign k1 = k0 + SlotW'(1);

    assign last_idx = (r_len == '0) ? '0
                    : (r_len > thx_pkg::LenW'(thx_pkg::MaxVector)) ? ElemW'(thx_pkg::MaxVector - 1)
                    : ElemW'(r_len - thx_pkg::LenW'(1));

    // commit placement
    always_comb begin
        ce     = (r_count >= CountW'(thx_pkg::TableDepth)) ? SlotW'(thx_pkg::TableDepth - 1)
                                                           : r_count[SlotW-1:0];
        if (r_rep) begin
            cp     = r_pos[SlotW-1:0];
            cslot  = r_ord[r_pos[SlotW-1:0]];
            ccount = r_count;
            keep   = thx_pkg::CleanKeepReplace;
        end else begin
            cp     = (r_pos > {1'b0, ce}) ? ce : r_pos[SlotW-1:0];
            cslot  = r_ord[ce];
            ccount = {1'b0, ce} + CountW'(1);
            keep   = thx_pkg::CleanKeepInsert;
        end
        n_count = ccount;
        if (cp < thx_pkg::CleanPosLimit && (r_rep || cp != '0)
                && ccount > thx_pkg::CleanThreshold && ccount > keep) begin
            n_count = keep;
        end
    end

    // memory ports
    assign t_raddr = (r_state == thx_pkg::S_QRD2) ? r_ord[k1] : r_ord[k0];
    assign v_raddr = (r_state == thx_pkg::S_V2) ? {r_ord[k1], r_vi} : {r_ord[k0], r_vi};
    assign t_we    = (r_state == thx_pkg::S_CCP);
    assign v_we    = (r_state == thx_pkg::S_CVAL);

    thx_ram #(.Width(TimeW), .Depth(thx_pkg::TableDepth)) u_times (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (cslot),
        .i_wdata (r_t),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    thx_ram #(.Width(ValW), .Depth(thx_pkg::TableDepth * thx_pkg::MaxVector)) u_values (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr ({r_slot, r_vi}),
        .i_wdata (r_stage[r_vi]),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    // extrapolation setup, v2 arrives on the value read port
    always_comb begin
        dv    = {r_v1[ValW-1], r_v1} - {v_rdata[ValW-1], v_rdata};
        a_sw  = r_t < r_t2;
        d_sw  = r_t1 < r_t2;
        s_m   = dv[MagW-1] ? (MagW'(0) - dv) : dv;
        s_a   = a_sw ? (r_t2 - r_t) : (r_t - r_t2);
        s_d   = d_sw ? (r_t2 - r_t1) : (r_t1 - r_t2);
        s_neg = dv[MagW-1] ^ a_sw ^ d_sw;
    end

    assign rem_sh = {r_rem, r_prod[ProdW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_d};
    assign rem_df = rem_sh - {1'b0, r_d};

    always_comb begin
        q_sat = (|r_prod[ProdW-1:41]) || (r_prod[40] && (|r_prod[39:0]));
        q_ext = q_sat ? {2'b0, 1'b1, 40'b0} : {2'b0, r_prod[40:0]};
        sum   = {{11{r_v2[ValW-1]}}, r_v2} + (r_neg ? (43'd0 - q_ext) : q_ext);
        if (!sum[42] && (|sum[41:31])) begin
            fin_val = 32'h7FFF_FFFF;
        end else if (sum[42] && !(&sum[41:31])) begin
            fin_val = 32'h8000_0000;
        end else begin
            fin_val = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thx_pkg::S_IDLE;
            r_len   <= thx_pkg::LenW'(1);
            r_count <= '0;
            r_ov    <= 1'b0;
            for (int j = 0; j < thx_pkg::TableDepth; j++) begin
                r_ord[j] <= SlotW'(j);
            end
        end else begin
            if (cfg_wr && paddr[2] == thx_pkg::REG_VECTOR_LENGTH) begin
                r_len <= pwdata[thx_pkg::LenW-1:0];
            end
            case (r_state)
                thx_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_t  <= in_time;
                        r_k  <= '0;
                        r_vi <= '0;
                        if (s_axis_tuser == thx_pkg::MODE_INSERT) begin
                            r_stage[in_idx] <= in_val;
                            if (s_axis_tlast) begin
                                r_state <= thx_pkg::S_CRD;
                            end
                        end else if (r_count == '0) begin
                            r_ov    <= 1'b1;
                            r_oval  <= '0;
                            r_oidx  <= '0;
                            r_olast <= 1'b1;
                            r_ostat <= thx_pkg::STATUS_EMPTY;
                            r_state <= thx_pkg::S_OUT;
                        end else begin
                            r_state <= thx_pkg::S_QRD;
                        end
                    end
                end
                thx_pkg::S_CRD: begin
                    if (r_k >= r_count) begin
                        r_pos   <= r_k;
                        r_rep   <= 1'b0;
                        r_state <= thx_pkg::S_CCP;
                    end else begin
                        r_state <= thx_pkg::S_CCMP;
                    end
                end
                thx_pkg::S_CCMP: begin
                    if (t_rdata > r_t) begin
                        r_k     <= r_k + CountW'(1);
                        r_state <= thx_pkg::S_CRD;
                    end else begin
                        r_pos   <= r_k;
                        r_rep   <= (t_rdata == r_t);
                        r_state <= thx_pkg::S_CCP;
                    end
                end
                thx_pkg::S_CCP: begin
                    r_slot  <= cslot;
                    r_count <= n_count;
                    r_vi    <= '0;
                    if (!r_rep) begin
                        for (int j = 1; j < thx_pkg::TableDepth; j++) begin
                            if (SlotW'(j) > cp && SlotW'(j) <= ce) begin
                                r_ord[j] <= r_ord[j-1];
                            end
                        end
                        r_ord[cp] <= cslot;
                    end
                    r_state <= thx_pkg::S_CVAL;
                end
                thx_pkg::S_CVAL: begin
                    r_vi <= r_vi + ElemW'(1);
                    if (r_vi == ElemW'(thx_pkg::MaxVector - 1)) begin
                        r_state <= thx_pkg::S_IDLE;
                    end
                end
                thx_pkg::S_QRD: begin
                    r_state <= thx_pkg::S_QCMP;
                end
                thx_pkg::S_QCMP: begin
                    r_t1 <= t_rdata;
                    if (t_rdata == r_t) begin
                        r_hn    <= 1'b0;
                        r_state <= thx_pkg::S_V1;
                    end else if (t_rdata < r_t) begin
                        r_hn    <= (r_k + CountW'(1)) < r_count;
                        r_state <= ((r_k + CountW'(1)) < r_count) ? thx_pkg::S_QRD2
                                                                  : thx_pkg::S_V1;
                    end else if ((r_k + CountW'(1)) >= r_count) begin
                        r_hn    <= 1'b0;
                        r_state <= thx_pkg::S_V1;
                    end else begin
                        r_k     <= r_k + CountW'(1);
                        r_state <= thx_pkg::S_QRD;
                    end
                end
                thx_pkg::S_QRD2: begin
                    r_state <= thx_pkg::S_QCMP2;
                end
                thx_pkg::S_QCMP2: begin
                    r_t2    <= t_rdata;
                    r_state <= thx_pkg::S_V1;
                end
                thx_pkg::S_V1: begin
                    r_state <= thx_pkg::S_V2;
                end
                thx_pkg::S_V2: begin
                    r_v1 <= v_rdata;
                    if (r_hn) begin
                        r_state <= thx_pkg::S_SET;
                    end else begin
                        r_ov    <= 1'b1;
                        r_oval  <= v_rdata;
                        r_oidx  <= r_vi;
                        r_olast <= (r_vi == last_idx);
                        r_ostat <= thx_pkg::STATUS_OK;
                        r_state <= thx_pkg::S_OUT;
                    end
                end
                thx_pkg::S_SET: begin
                    r_v2   <= v_rdata;
                    r_a    <= s_a;
                    r_m    <= s_m;
                    r_d    <= s_d;
                    r_neg  <= s_neg;
                    r_prod <= '0;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    if (r_t1 == r_t2 || r_v1 == v_rdata) begin
                        r_ov    <= 1'b1;
                        r_oval  <= r_v1;
                        r_oidx  <= r_vi;
                        r_olast <= (r_vi == last_idx);
                        r_ostat <= thx_pkg::STATUS_OK;
                        r_state <= thx_pkg::S_OUT;
                    end else begin
                        r_state <= thx_pkg::S_MUL;
                    end
                end
                thx_pkg::S_MUL: begin
                    r_prod <= {r_prod[ProdW-2:0], 1'b0}
                            + (r_m[MagW-1] ? {33'b0, r_a} : '0);
                    r_m    <= {r_m[MagW-2:0], 1'b0};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(MagW - 1)) begin
                        r_cnt   <= '0;
                        r_state <= thx_pkg::S_DIV;
                    end
                end
                thx_pkg::S_DIV: begin
                    r_rem  <= rem_ge ? rem_df[TimeW-1:0] : rem_sh[TimeW-1:0];
                    r_prod <= {r_prod[ProdW-2:0], rem_ge};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(ProdW - 1)) begin
                        r_state <= thx_pkg::S_FIN;
                    end
                end
                thx_pkg::S_FIN: begin
                    r_ov    <= 1'b1;
                    r_oval  <= fin_val;
                    r_oidx  <= r_vi;
                    r_olast <= (r_vi == last_idx);
                    r_ostat <= thx_pkg::STATUS_OK;
                    r_state <= thx_pkg::S_OUT;
                end
                thx_pkg::S_OUT: begin
                    if (m_axis_tready) begin
                        r_ov <= 1'b0;
                        if (r_olast) begin
                            r_state <= thx_pkg::S_IDLE;
                        end else begin
                            r_vi    <= r_vi + ElemW'(1);
                            r_state <= thx_pkg::S_V1;
                        end
                    end
                end
                default: begin
                    r_state <= thx_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/thx_checker.sv */
// Port-level assertions for the time history extrapolator, bound to the top level.
module thx_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [thx_pkg::OutDataW-1:0] m_axis_tdata,
    input logic                         m_axis_tlast,
    input logic                         m_axis_tuser,
    input logic                         pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == thx_pkg::STATUS_EMPTY
        |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("empty-table beat malformed");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && pready)
        else $error("output valid after reset");

endmodule

bind time_history_extrapolator thx_checker u_thx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);

/* tb/tb_time_history_extrapolator.sv */
// Self-checking testbench of the time history extrapolator: directed table plus random stream.
`timescale 1ns / 1ps

module tb_time_history_extrapolator;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SETTLE       = 300;

    typedef struct packed {
        logic [31:0] val;
        logic [3:0]  idx;
        logic        last;
        logic        status;
    } t_result;

    typedef struct {
        logic        mode;
        logic [47:0] t;
        logic [3:0]  idx;
        logic [31:0] v;
        logic        last;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [87:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic s_tuser = 1'b0;
    logic s_tready;
    logic m_tvalid, m_tlast, m_tuser;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    time_history_extrapolator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata),   // time_req, elem_index, value
        .s_axis_tlast(s_tlast),
        .s_axis_tuser(s_tuser),   // mode
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata),   // result_value, result_index
        .m_axis_tlast(m_tlast),
        .m_axis_tuser(m_tuser),   // status
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table image
    logic [47:0] tab_time [thx_pkg::TableDepth];
    int          tab_val  [thx_pkg::TableDepth][thx_pkg::MaxVector];
    int          tab_count;
    int          stage    [thx_pkg::MaxVector];
    int          vec_len;

    t_result pending_results[$];
    int      errors;
    int      cycles;
    bit      idling;
    int      stall_left;

    function automatic int extrapolate(logic [47:0] t, int v1, logic [47:0] t1,
                                       int v2, logic [47:0] t2);
        longint      dv, r;
        logic [47:0] a, d;
        logic [32:0] m;
        logic [127:0] prod, q;
        bit          neg;
        if (t1 == t2 || v1 == v2) return v1;
        dv  = longint'(v1) - longint'(v2);
        neg = dv < 0;
        m   = neg ? 33'(-dv) : 33'(dv);
        if (t >= t2) a = t - t2; else begin a = t2 - t; neg = !neg; end
        if (t1 >= t2) d = t1 - t2; else begin d = t2 - t1; neg = !neg; end
        prod = 128'(a) * 128'(m);
        q = prod / 128'(d);
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        r = longint'(v2) + (neg ? -longint'(q[40:0]) : longint'(q[40:0]));
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return int'(r);
    endfunction

    function automatic void commit_vector(logic [47:0] t);
        int  pos, keep;
        bit  repl;
        pos = 0;
        while (pos < tab_count && tab_time[pos] > t) pos++;
        repl = pos < tab_count && tab_time[pos] == t;
        if (!repl) begin
            if (tab_count >= thx_pkg::TableDepth) tab_count = thx_pkg::TableDepth - 1;
            if (pos > tab_count) pos = tab_count;
            for (int j = tab_count; j > pos; j--) begin
                tab_time[j] = tab_time[j-1];
                tab_val[j]  = tab_val[j-1];
            end
            tab_count++;
        end
        tab_time[pos] = t;
        tab_val[pos]  = stage;
        if (pos < 3 && (repl || pos >= 1) && tab_count > 20) begin
            keep = repl ? 5 : 6;
            if (tab_count > keep) tab_count = keep;
        end
    endfunction

    function automatic void apply_item(t_row it);
        int  k, n, r;
        bit  has_next;
        if (it.mode == thx_pkg::MODE_INSERT) begin
            stage[it.idx] = it.v;
            if (it.last) commit_vector(it.t);
            return;
        end
        if (tab_count == 0) begin
            pending_results.push_back('{32'd0, 4'd0, 1'b1, thx_pkg::STATUS_EMPTY});
            return;
        end
        k = 0;
        has_next = 0;
        forever begin
            if (tab_time[k] == it.t) break;
            if (tab_time[k] < it.t) begin
                has_next = (k + 1) < tab_count;
                break;
            end
            if (k + 1 >= tab_count) break;
            k++;
        end
        n = (vec_len == 0) ? 1 : (vec_len > thx_pkg::MaxVector) ? thx_pkg::MaxVector : vec_len;
        for (int i = 0; i < n; i++) begin
            r = tab_val[k][i];
            if (has_next)
                r = extrapolate(it.t, r, tab_time[k], tab_val[k+1][i], tab_time[k+1]);
            pending_results.push_back('{32'(r), 4'(i), 1'(i + 1 == n), thx_pkg::STATUS_OK});
        end
    endfunction

    task automatic send(t_row it);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.v, it.idx, it.t};
        s_tlast  <= it.last;
        s_tuser  <= it.mode;
        do @(posedge i_clk); while (!s_tready);
        apply_item(it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(logic [31:0] len);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(thx_pkg::REG_VECTOR_LENGTH) << 2;
        pwdata  <= len;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        vec_len = int'(len & 32'h1F);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 200)) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] rand_stamp();
        logic [47:0] t;
        case ($urandom_range(0, 5))
            0: t = tab_count ? tab_time[$urandom_range(0, tab_count - 1)] : 48'd0;
            1: t = (tab_count ? tab_time[$urandom_range(0, tab_count - 1)] : 48'd0)
                   + 48'($urandom_range(0, 4000)) - 48'd2000;
            2: t = 48'({$urandom, $urandom});
            3: t = $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'($urandom_range(0, 3));
            default: t = 48'($urandom_range(0, 1000)) << 16 | 48'($urandom_range(0, 65535));
        endcase
        return t;
    endfunction

    task automatic run_random(int count);
        int issued, k;
        t_row it;
        issued = 0;
        while (issued < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    k = $urandom_range(1, 4);
                    it.t = rand_stamp();
                    for (int j = 0; j < k; j++) begin
                        it.mode = thx_pkg::MODE_INSERT;
                        it.idx  = 4'($urandom);
                        it.v    = rand_value();
                        it.last = (j == k - 1);
                        send(it);
                    end
                    issued += k;
                end
                6, 7, 8: begin
                    it = '{thx_pkg::MODE_QUERY, rand_stamp(), 4'($urandom), $urandom,
                           1'($urandom)};
                    send(it);
                    issued++;
                end
                default: begin
                    // stray element, no commit
                    it = '{thx_pkg::MODE_INSERT, 48'({$urandom, $urandom}), 4'($urandom),
                           rand_value(), 1'b0};
                    send(it);
                    issued++;
                end
            endcase
        end
    endtask

    // receiver with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected beat: got val %h idx %0d last %b status %b",
                             $time, m_tdata[31:0], m_tdata[35:32], m_tlast, m_tuser);
                    errors++;
                end else begin
                    t_result want;
                    want = pending_results.pop_front();
                    if (want != {m_tdata[31:0], m_tdata[35:32], m_tlast, m_tuser}) begin
                        $display("%0t mismatch: expected val %h idx %0d last %b status %b, got val %h idx %0d last %b status %b",
                                 $time, want.val, want.idx, want.last, want.status,
                                 m_tdata[31:0], m_tdata[35:32], m_tlast, m_tuser);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_row dir_rows [9];
        t_row it;
        logic [47:0] t;
        errors    = 0;
        cycles    = 0;
        tab_count = 0;
        vec_len   = 1;
        idling    = 1;
        dir_rows = '{
            '{thx_pkg::MODE_QUERY,  48'h0000_0064_0000, 4'd0,  32'd0,         1'b0},
            '{thx_pkg::MODE_INSERT, 48'h0000_00C8_0000, 4'd0,  32'h7FFF_FFFF, 1'b0},
            '{thx_pkg::MODE_INSERT, 48'h0000_00C8_0000, 4'd15, 32'h8000_0000, 1'b1},
            '{thx_pkg::MODE_QUERY,  48'h0000_0096_8000, 4'd0,  32'd0,         1'b0},
            '{thx_pkg::MODE_QUERY,  48'hFFFF_FFFF_FFFF, 4'd0,  32'd0,         1'b0},
            '{thx_pkg::MODE_QUERY,  48'h0000_0000_0000, 4'd0,  32'd0,         1'b0},
            '{thx_pkg::MODE_INSERT, 48'h0000_00C8_0000, 4'd1,  32'd0,         1'b1},
            '{thx_pkg::MODE_QUERY,  48'h0000_00C8_0000, 4'd0,  32'd0,         1'b1},
            '{thx_pkg::MODE_QUERY,  48'h0000_0032_0000, 4'd0,  32'd0,         1'b0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_length(32'd16);
        // empty table: single beat with the empty flag
        it = '{thx_pkg::MODE_QUERY, 48'd0, 4'd0, 32'd0, 1'b0};
        send(it);
        if (pending_results.size() != 1 ||
            pending_results[0] != t_result'{32'd0, 4'd0, 1'b1, thx_pkg::STATUS_EMPTY}) begin
            $display("%0t mismatch: expected empty-table beat, predictor disagrees", $time);
            errors++;
        end
        // load every staging element once
        for (int i = 0; i < thx_pkg::MaxVector; i++) begin
            it = '{thx_pkg::MODE_INSERT, 48'h0000_0064_0000, 4'(i),
                   (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7FFF_FFFF : $urandom,
                   1'(i == thx_pkg::MaxVector - 1)};
            send(it);
        end
        foreach (dir_rows[i]) send(dir_rows[i]);

        run_random(30);
        wait_drained();

        // fill the table with ever older stamps to reach the full case
        for (int i = 0; i < 36; i++) begin
            t = tab_count ? tab_time[tab_count - 1] : 48'h0000_1000_0000;
            t = (t > 48'd2) ? t - 48'd1 - 48'($urandom_range(0, 1)) : 48'h0000_1000_0000;
            it = '{thx_pkg::MODE_INSERT, t, 4'($urandom), rand_value(), 1'b1};
            send(it);
        end
        it = '{thx_pkg::MODE_QUERY, 48'd0, 4'd0, 32'd0, 1'b0};
        send(it);
        if (tab_count > 1) begin
            it = '{thx_pkg::MODE_INSERT, tab_time[1] + 48'd1, 4'd3, rand_value(), 1'b1};
            if (it.t < tab_time[0]) send(it);
        end

        write_length(32'd1);
        run_random(40);
        write_length(32'd0);
        run_random(20);
        write_length(32'd31);
        run_random(20);
        write_length(32'($urandom_range(2, 15)));
        idling = 0;
        run_random(50);

        wait_drained();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/thx_pkg.sv
sv/thx_ram.sv
sv/time_history_extrapolator.sv
sv/thx_checker.sv
tb/tb_time_history_extrapolator.sv
